>>> rtl/sks_pkg.sv
// Shared types, constants, S-box tables and the G function of the key schedule.
package sks_pkg;

    localparam logic [31:0] KC_BASE  = 32'h9e3779b9;
    localparam logic [7:0]  GF_POLY  = 8'h63;
    localparam logic [7:0]  EXP_ONE  = 8'hF7;
    localparam logic [7:0]  EXP_TWO  = 8'hFB;
    localparam logic [7:0]  XOR_ONE  = 8'hA9;
    localparam logic [7:0]  XOR_TWO  = 8'h38;
    localparam logic [63:0] MAT_ONE  = 64'hE2584441C269D02C;
    localparam logic [63:0] MAT_TWO  = 64'h6CA230212CE12AD0;

    localparam logic [31:0] MASK_Y0  = 32'h3FCFF3FC;
    localparam logic [31:0] MASK_Y1  = 32'hFC3FCFF3;
    localparam logic [31:0] MASK_Y2  = 32'hF3FC3FCF;
    localparam logic [31:0] MASK_Y3  = 32'hCFF3FC3F;

    localparam int          KEYS_PER_ITEM = 32;
    localparam int          POS_W         = $clog2(KEYS_PER_ITEM);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(KEYS_PER_ITEM - 1);

    localparam int          KEY_QUEUE_DEPTH = 2;
    localparam int          RESULT_DEPTH    = 4;

    typedef struct packed {
        logic [31:0] key_word_a;
        logic [31:0] key_word_b;
        logic [31:0] key_word_c;
        logic [31:0] key_word_d;
    } key_item_t;

    typedef struct packed {
        logic [31:0]      round_key;
        logic [POS_W-1:0] key_position;
        logic             last_key;
    } result_t;

    typedef logic [255:0][7:0] sbox_t;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] aa;
        r  = 8'h00;
        aa = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ aa;
            end
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? GF_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_power(input logic [7:0] x, input logic [7:0] e);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 7; i >= 0; i--)
        begin
            r = gf_times(r, r);
            if (e[i])
            begin
                r = gf_times(r, x);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] affine(input logic [63:0] rows, input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7-i])
            begin
                r = r ^ rows[63-8*i -: 8];
            end
        end
        return r;
    endfunction

    function automatic sbox_t make_sbox(input logic [63:0] rows, input logic [7:0] ex,
                                        input logic [7:0] c);
        sbox_t t;
        for (int v = 0; v < 256; v++)
        begin
            t[v] = affine(rows, gf_power(8'(v), ex)) ^ c;
        end
        return t;
    endfunction

    localparam sbox_t SBOX_ONE = make_sbox(MAT_ONE, EXP_ONE, XOR_ONE);
    localparam sbox_t SBOX_TWO = make_sbox(MAT_TWO, EXP_TWO, XOR_TWO);

    function automatic logic [31:0] seed_g(input logic [31:0] x);
        logic [31:0] y0;
        logic [31:0] y1;
        logic [31:0] y2;
        logic [31:0] y3;
        y0 = {4{SBOX_ONE[x[7:0]]}};
        y1 = {4{SBOX_TWO[x[15:8]]}};
        y2 = {4{SBOX_ONE[x[23:16]]}};
        y3 = {4{SBOX_TWO[x[31:24]]}};
        return (y0 & MASK_Y0) ^ (y1 & MASK_Y1) ^ (y2 & MASK_Y2) ^ (y3 & MASK_Y3);
    endfunction

endpackage

>>> rtl/sks_fifo.sv
// Small synchronous FIFO used for the key queue and the result queue.
module sks_fifo
    import sks_pkg::*;
#(
    parameter type T     = key_item_t,
    parameter int  DEPTH = KEY_QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  T                 wr_data,
    output logic             full,
    input  logic             pop,
    output T                 rd_data,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    T                 mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/sks_round_engine.sv
// Round engine: key rotation, round-constant update, key sums and the G stage.
module sks_round_engine
    import sks_pkg::*;
#(
    parameter int  RESULT_DEPTH = sks_pkg::RESULT_DEPTH,
    localparam int CNT_W        = $clog2(RESULT_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_valid,
    input  key_item_t        key_item,
    output logic             key_pop,
    input  logic [CNT_W-1:0] res_count,
    output logic             res_push,
    output result_t          res_data
);

    logic             busy_reg;
    logic             busy_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             s1_valid_reg;
    logic [31:0]      k0_reg, k1_reg, k2_reg, k3_reg;
    logic [31:0]      k0_next, k1_next, k2_next, k3_next;
    logic [31:0]      kc_reg;
    logic [31:0]      kc_next;
    logic [31:0]      sum_reg;
    logic [31:0]      sum_next;
    logic [POS_W-1:0] s1_pos_reg;
    logic [CNT_W:0]   committed;
    logic             issue;
    logic             load;
    logic             last_pos;

    assign committed = {1'b0, res_count} + (CNT_W + 1)'(s1_valid_reg);
    assign issue     = busy_reg && (committed < (CNT_W + 1)'(RESULT_DEPTH));
    assign last_pos  = (pos_reg == LAST_POS);
    assign load      = key_valid && (!busy_reg || (issue && last_pos));
    assign key_pop   = load;
    assign sum_next  = pos_reg[0] ? (k1_reg - k3_reg + kc_reg) : (k0_reg + k2_reg - kc_reg);

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        k0_next   = k0_reg;
        k1_next   = k1_reg;
        k2_next   = k2_reg;
        k3_next   = k3_reg;
        kc_next   = kc_reg;
        if (issue)
        begin
            pos_next = pos_reg + 1'b1;
            if (last_pos)
            begin
                busy_next = 1'b0;
            end
            if (pos_reg[0])
            begin
                kc_next = {kc_reg[30:0], kc_reg[31]};
                if (pos_reg[1])
                begin
                    k2_next = {k2_reg[23:0], k3_reg[31:24]};
                    k3_next = {k3_reg[23:0], k2_reg[31:24]};
                end
                else
                begin
                    k0_next = {k1_reg[7:0], k0_reg[31:8]};
                    k1_next = {k0_reg[7:0], k1_reg[31:8]};
                end
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            k0_next   = key_item.key_word_a;
            k1_next   = key_item.key_word_b;
            k2_next   = key_item.key_word_c;
            k3_next   = key_item.key_word_d;
            kc_next   = KC_BASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        k2_reg <= k2_next;
        k3_reg <= k3_next;
        kc_reg <= kc_next;
        if (issue)
        begin
            sum_reg    <= sum_next;
            s1_pos_reg <= pos_reg;
        end
    end

    assign res_push              = s1_valid_reg;
    assign res_data.round_key    = seed_g(sum_reg);
    assign res_data.key_position = s1_pos_reg;
    assign res_data.last_key     = (s1_pos_reg == LAST_POS);

endmodule

>>> rtl/seed_key_schedule_unit.sv
// Top level of the SEED-128 key schedule unit.
// Each accepted 128-bit key produces 32 round-key words; the round engine
// issues one word per clock cycle while the result queue has room. Keys
// wait in a small input queue while the engine works on an earlier key, and
// finished words wait in a result queue, so either side may stall
// independently. The last word of every key carries last_key.
module seed_key_schedule_unit
    import sks_pkg::*;
#(
    parameter int KEY_QUEUE_DEPTH = sks_pkg::KEY_QUEUE_DEPTH,
    parameter int RESULT_DEPTH    = sks_pkg::RESULT_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  key_item_t item,
    output logic      full,
    input  logic      pop,
    output result_t   result,
    output logic      empty
);

    localparam int RES_CNT_W = $clog2(RESULT_DEPTH + 1);

    key_item_t            key_head;
    logic                 key_empty;
    logic                 key_pop;
    logic                 res_push;
    result_t              res_data;
    logic [RES_CNT_W-1:0] res_count;

    sks_fifo #(
        .T     (key_item_t),
        .DEPTH (KEY_QUEUE_DEPTH)
    ) u_key_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (item),
        .full    (full),
        .pop     (key_pop),
        .rd_data (key_head),
        .empty   (key_empty),
        .count   ()
    );

    sks_round_engine #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_round_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (!key_empty),
        .key_item  (key_head),
        .key_pop   (key_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    sks_fifo #(
        .T     (result_t),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty),
        .count   (res_count)
    );

endmodule

>>> tb/sks_round_key_checker.sv
`timescale 1ns / 100ps
// Checker for the key schedule unit: predicts the round keys of every key transfer and compares.
module sks_round_key_checker
    import sks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  key_item_t item,
    input  logic      pop,
    input  logic      empty,
    input  result_t   result,
    output int        fail_count,
    output int        pending
);

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
    localparam logic [63:0] ROWS_S1      = 64'hE2584441C269D02C;
    localparam logic [63:0] ROWS_S2      = 64'h6CA230212CE12AD0;

    logic [7:0] s1_rom [256];
    logic [7:0] s2_rom [256];
    result_t    round_keys_due [$];
    result_t    want;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ sh;
            end
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h63 : 8'h00);
        end
        return acc;
    endfunction

    // right-to-left square and multiply
    function automatic logic [7:0] gf_pow(input logic [7:0] x, input logic [7:0] e);
        logic [7:0] acc;
        logic [7:0] base;
        acc  = 8'h01;
        base = x;
        for (int i = 0; i < 8; i++)
        begin
            if (e[i])
            begin
                acc = gf_mul(acc, base);
            end
            base = gf_mul(base, base);
        end
        return acc;
    endfunction

    function automatic logic [7:0] bit_matrix(input logic [63:0] rows, input logic [7:0] v);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7-i])
            begin
                acc = acc ^ 8'(rows >> (56 - 8 * i));
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] g_mix(input logic [31:0] x);
        logic [31:0] y0;
        logic [31:0] y1;
        logic [31:0] y2;
        logic [31:0] y3;
        y0 = {4{s1_rom[x[7:0]]}};
        y1 = {4{s2_rom[x[15:8]]}};
        y2 = {4{s1_rom[x[23:16]]}};
        y3 = {4{s2_rom[x[31:24]]}};
        return (y0 & 32'h3FCFF3FC) ^ (y1 & 32'hFC3FCFF3) ^
               (y2 & 32'hF3FC3FCF) ^ (y3 & 32'hCFF3FC3F);
    endfunction

    task automatic expand_key(input key_item_t k);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] kc;
        result_t     e;
        w0 = k.key_word_a;
        w1 = k.key_word_b;
        w2 = k.key_word_c;
        w3 = k.key_word_d;
        for (int r = 0; r < 16; r++)
        begin
            kc = (GOLDEN_RATIO << r) | (GOLDEN_RATIO >> (32 - r));
            e.round_key    = g_mix(w0 + w2 - kc);
            e.key_position = POS_W'(2 * r);
            e.last_key     = 1'b0;
            round_keys_due.push_back(e);
            e.round_key    = g_mix(w1 - w3 + kc);
            e.key_position = POS_W'(2 * r + 1);
            e.last_key     = (r == 15);
            round_keys_due.push_back(e);
            if (r % 2 == 1)
            begin
                {w2, w3} = {w2[23:0], w3, w2[31:24]};
            end
            else
            begin
                {w0, w1} = {w1[7:0], w0, w1[31:8]};
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] round key check: %s: got %h, expected %h", $time, what, got, exp_val);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        for (int v = 0; v < 256; v++)
        begin
            s1_rom[v] = bit_matrix(ROWS_S1, gf_pow(8'(v), 8'hF7)) ^ 8'hA9;
            s2_rom[v] = bit_matrix(ROWS_S2, gf_pow(8'(v), 8'hFB)) ^ 8'h38;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                expand_key(item);
            end
            if (pop && !empty)
            begin
                if (round_keys_due.size() == 0)
                begin
                    report_mismatch("result transfer with nothing due", result.round_key, '0);
                end
                else
                begin
                    want = round_keys_due.pop_front();
                    if (result.round_key !== want.round_key)
                    begin
                        report_mismatch("round_key", result.round_key, want.round_key);
                    end
                    if (result.key_position !== want.key_position)
                    begin
                        report_mismatch("key_position", 32'(result.key_position),
                                        32'(want.key_position));
                    end
                    if (result.last_key !== want.last_key)
                    begin
                        report_mismatch("last_key", 32'(result.last_key), 32'(want.last_key));
                    end
                end
            end
            pending = round_keys_due.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, key and pop stimulus, watchdog and verdict.
module tb;
    import sks_pkg::*;

    localparam int RANDOM_KEYS    = 420;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 500;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;
    key_item_t item;
    result_t   result;
    int        fail_count;
    int        pending;
    int        idle_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    seed_key_schedule_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    sks_round_key_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .pop        (pop),
        .empty      (empty),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [31:0] random_word();
        int          mode;
        logic [31:0] w;
        mode = $urandom_range(0, 5);
        case (mode)
            3:       w = $urandom & $urandom & $urandom;
            4:       w = $urandom | $urandom | $urandom;
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       w = 32'h00000000;
                    1:       w = 32'hFFFFFFFF;
                    2:       w = 32'h80000000;
                    default: w = 32'h00000001;
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic offer_key(input key_item_t k);
        @(negedge clk);
        push <= 1'b1;
        item <= k;
        do
        begin
            @(posedge clk);
        end
        while (full);
    endtask

    task automatic sender_pause(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // key source
    initial
    begin
        key_item_t directed [$];
        key_item_t k;
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        directed.push_back('{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000});
        directed.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        directed.push_back('{32'h00010203, 32'h04050607, 32'h08090A0B, 32'h0C0D0E0F});
        directed.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        directed.push_back('{32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001});
        directed.push_back('{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA});
        directed.push_back('{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555});
        directed.push_back('{32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000});
        directed.push_back('{32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF});
        // sums that hit zero after the constant in the first round
        directed.push_back('{32'h9e3779b9, 32'h00000000, 32'h00000000, 32'h9e3779b9});
        directed.push_back('{32'h4f1bbcdc, 32'h12345678, 32'h4f1bbcdd, 32'hb06cdcbf});
        directed.push_back('{32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210});
        directed.push_back('{32'hFF00FF00, 32'h00FF00FF, 32'h0F0F0F0F, 32'hF0F0F0F0});
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
        begin
            offer_key(directed[i]);
            sender_pause(pick_gap());
        end
        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            k.key_word_a = random_word();
            k.key_word_b = random_word();
            k.key_word_c = random_word();
            k.key_word_d = random_word();
            offer_key(k);
            if (n < 150 || n >= 210)
            begin
                sender_pause(pick_gap());
            end
        end
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("seed_key_schedule_unit verification clean");
        end
        else
        begin
            $display("seed_key_schedule_unit verification failed");
        end
        $finish;
    end

    // result sink, with one long hold-off to back the unit up
    initial
    begin
        int taken;
        int gap;
        taken = 0;
        pop   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pop <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (empty);
            taken++;
            if (taken == HOLD_AT)
            begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (taken < 2000 || taken > 2600)
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
                $display("seed_key_schedule_unit verification failed");
                $finish;
            end
        end
    end

endmodule
